### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define DWCC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication, next-cycle form
`define DWCC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/dwcc_pkg.sv
`default_nettype none
package dwcc_pkg;

  localparam int unsigned SQ_OP_W = 40;
  localparam int unsigned SQ_ACC_W = 82;

  localparam logic REG_TARGET_CLASS   = 1'b0;
  localparam logic REG_DISTANCE_LIMIT = 1'b1;

  localparam logic KIND_DETECT = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [1:0]         row;
    logic               present;
    logic [7:0]         class_id;
    logic [15:0]        score;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] offset;
    logic               last;
  } det_word_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } res_word_t;

endpackage
`default_nettype wire

### hw/rtl/dwcc_ram.sv
`default_nettype none
module dwcc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 5
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/detection_window_consistency_check.sv
`default_nettype none
// Qualifies point-source detections. Load words (kind 1) write one transform row (row 3 is
// ignored); detection words that do not close a frame are taken without leaving IDLE. A
// frame-closing word with a winner and a full window goes through the accept, nine products
// through one 32x32 multiplier (three per row, then rounding), the write-back, a walk of the
// history RAM (one entry at a time, single read port), the deviation step, then four
// squarings on a second 32x32 multiplier, the compare and the result load. A closing word
// with a winner but a window that is not yet full goes from the write-back to the result
// load, and a closing word without a winner reads the old slot entry between the two. One
// result word leaves per closing word; the result load waits while the previous result
// word is unread, and a result word may wait in the output register while the next word is accepted.
module detection_window_consistency_check #(
  parameter int unsigned WINDOW = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                det_valid,
  output logic                     det_ready,
  input  wire dwcc_pkg::det_word_t det,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output dwcc_pkg::res_word_t      res,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_data
);
  import dwcc_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned SW = 33 + AW;
  localparam int unsigned DW = SW + 1;

  typedef enum logic [3:0] {
    IDLE, XMUL, XACC, XFIN, WR, OLD, SUMRD, SUMAC, DEV, SQ0, SQ1, SQ2, CMP, DONE
  } state_t;

  state_t state;

  logic [7:0]          target_class;
  logic [30:0]         distance_limit;
  logic signed [31:0]  coef [12];
  logic [WINDOW-1:0]   found;
  logic [WINDOW-1:0]   written;
  logic [AW-1:0]       slot;
  logic [AW-1:0]       idx;
  logic                best_seen;
  logic [15:0]         best_score;
  logic signed [31:0]  best_x, best_y, best_z;
  logic [1:0]          r, c, q;
  logic signed [63:0]  prod;
  logic signed [65:0]  acc;
  logic signed [31:0]  newpos [3];
  logic signed [SW-1:0] sx, sy, sz;
  logic [SQ_OP_W-1:0]  dabs [3];
  logic [SQ_ACC_W-1:0] mp, acc_l, acc_r;
  logic                ok;
  logic                wrote_q;
  logic signed [31:0]  pos_q [3];

  // history RAM
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [95:0]   ram_rdata;

  dwcc_ram #(.WIDTH(96), .DEPTH(WINDOW)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({newpos[0], newpos[1], newpos[2]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state == WR) && best_seen;
  assign ram_raddr = (state == WR) ? slot : idx;

  assign det_ready = (state == IDLE);
  assign cfg_ready = 1'b1;

  logic det_take;
  logic cand;
  logic res_load;
  assign det_take = det_valid && det_ready;
  assign cand = det.present && (det.class_id == target_class) &&
                (!best_seen || (det.score > best_score));
  assign res_load = (state == DONE) && (!res_valid || res_ready);

  logic signed [31:0] pmux;
  always_comb begin
    unique case (c)
      2'd0:    pmux = best_x;
      2'd1:    pmux = best_y;
      default: pmux = best_z;
    endcase
  end

  // rounding and saturation of one transformed coordinate
  logic signed [65:0] rnd, rsum;
  logic signed [31:0] rsat;
  assign rnd  = (acc + 66'sd32768) >>> 16;
  assign rsum = rnd + 66'(coef[{r, 2'd3}]);
  always_comb begin
    priority if (rsum > 66'sd2147483647) begin
      rsat = 32'sh7fffffff;
    end else if (rsum < -66'sd2147483648) begin
      rsat = 32'sh80000000;
    end else begin
      rsat = rsum[31:0];
    end
  end

  logic [WINDOW-1:0] slot_bit;
  assign slot_bit = WINDOW'(1) << slot;

  // deviation from window sum
  logic signed [DW-1:0] wk;
  logic signed [DW-1:0] dvx, dvy, dvz;
  assign wk  = DW'(WINDOW);
  assign dvx = DW'(sx) - DW'(newpos[0]) * wk;
  assign dvy = DW'(sy) - DW'(newpos[1]) * wk;
  assign dvz = DW'(sz) - DW'(newpos[2]) * wk;

  function automatic logic [SQ_OP_W-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return SQ_OP_W'(m);
  endfunction

  logic [34:0]         lim;
  logic [SQ_OP_W-1:0]  sq_op;
  logic [31:0]         vl;
  logic [7:0]          vh;
  logic [63:0]         sq_lo;
  logic [39:0]         sq_mid;
  logic [15:0]         sq_hh;
  assign lim = 35'(distance_limit) * 35'(WINDOW);
  always_comb begin
    unique case (q)
      2'd0:    sq_op = dabs[0];
      2'd1:    sq_op = dabs[1];
      2'd2:    sq_op = dabs[2];
      default: sq_op = SQ_OP_W'(lim);
    endcase
  end
  assign vl     = sq_op[31:0];
  assign vh     = sq_op[39:32];
  assign sq_lo  = {32'b0, vl} * {32'b0, vl};
  assign sq_mid = {8'b0, vl} * {32'b0, vh};
  assign sq_hh  = {8'b0, vh} * {8'b0, vh};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      target_class   <= 8'd0;
      distance_limit <= 31'd655;
      for (int i = 0; i < 12; i++) begin
        coef[i] <= 32'sd0;
      end
      found      <= '0;
      written    <= '0;
      slot       <= '0;
      idx        <= '0;
      best_seen  <= 1'b0;
      best_score <= 16'd0;
      best_x     <= 32'sd0;
      best_y     <= 32'sd0;
      best_z     <= 32'sd0;
      r          <= 2'd0;
      c          <= 2'd0;
      q          <= 2'd0;
      ok         <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TARGET_CLASS:   target_class   <= cfg_data[7:0];
          REG_DISTANCE_LIMIT: distance_limit <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (det_take) begin
            if (det.kind == KIND_LOAD) begin
              if (det.row != 2'd3) begin
                coef[{det.row, 2'd0}] <= det.x;
                coef[{det.row, 2'd1}] <= det.y;
                coef[{det.row, 2'd2}] <= det.z;
                coef[{det.row, 2'd3}] <= det.offset;
              end
            end else begin
              if (cand) begin
                best_seen  <= 1'b1;
                best_score <= det.score;
                best_x     <= det.x;
                best_y     <= det.y;
                best_z     <= det.z;
              end
              if (det.last) begin
                r   <= 2'd0;
                c   <= 2'd0;
                acc <= '0;
                state <= (cand || best_seen) ? XMUL : WR;
              end
            end
          end
        end
        XMUL: begin
          prod  <= coef[{r, c}] * pmux;
          state <= XACC;
        end
        XACC: begin
          acc <= acc + 66'(prod);
          if (c == 2'd2) begin
            state <= XFIN;
          end else begin
            c     <= c + 2'd1;
            state <= XMUL;
          end
        end
        XFIN: begin
          newpos[r] <= rsat;
          acc <= '0;
          c   <= 2'd0;
          if (r == 2'd2) begin
            state <= WR;
          end else begin
            r     <= r + 2'd1;
            state <= XMUL;
          end
        end
        WR: begin
          wrote_q <= written[slot];
          if (best_seen) begin
            found   <= found | slot_bit;
            written <= written | slot_bit;
            pos_q   <= newpos;
            if (&(found | slot_bit)) begin
              idx   <= '0;
              sx    <= '0;
              sy    <= '0;
              sz    <= '0;
              state <= SUMRD;
            end else begin
              ok    <= 1'b0;
              state <= DONE;
            end
          end else begin
            found <= found & ~slot_bit;
            state <= OLD;
          end
        end
        OLD: begin
          pos_q[0] <= wrote_q ? ram_rdata[95:64] : 32'sd0;
          pos_q[1] <= wrote_q ? ram_rdata[63:32] : 32'sd0;
          pos_q[2] <= wrote_q ? ram_rdata[31:0]  : 32'sd0;
          ok    <= 1'b0;
          state <= DONE;
        end
        SUMRD: begin
          state <= SUMAC;
        end
        SUMAC: begin
          sx <= sx + SW'($signed(ram_rdata[95:64]));
          sy <= sy + SW'($signed(ram_rdata[63:32]));
          sz <= sz + SW'($signed(ram_rdata[31:0]));
          if (idx == AW'(WINDOW - 1)) begin
            state <= DEV;
          end else begin
            idx   <= idx + AW'(1);
            state <= SUMRD;
          end
        end
        DEV: begin
          dabs[0] <= mag(dvx);
          dabs[1] <= mag(dvy);
          dabs[2] <= mag(dvz);
          acc_l   <= '0;
          acc_r   <= '0;
          q       <= 2'd0;
          state   <= SQ0;
        end
        SQ0: begin
          mp    <= SQ_ACC_W'(sq_lo);
          state <= SQ1;
        end
        SQ1, SQ2: begin
          if (q == 2'd3) begin
            acc_r <= acc_r + mp;
          end else begin
            acc_l <= acc_l + mp;
          end
          if (state == SQ1) begin
            mp    <= (SQ_ACC_W'(sq_mid) << 33) + (SQ_ACC_W'(sq_hh) << 64);
            state <= SQ2;
          end else if (q == 2'd3) begin
            state <= CMP;
          end else begin
            q     <= q + 2'd1;
            state <= SQ0;
          end
        end
        CMP: begin
          ok    <= (acc_l <= acc_r);
          state <= DONE;
        end
        DONE: begin
          if (res_load) begin
            res.valid_res <= ok;
            res.pos_x     <= pos_q[0];
            res.pos_y     <= pos_q[1];
            res.pos_z     <= pos_q[2];
            slot          <= (slot == AW'(WINDOW - 1)) ? '0 : slot + AW'(1);
            best_seen     <= 1'b0;
            best_score    <= 16'd0;
            best_x        <= 32'sd0;
            best_y        <= 32'sd0;
            best_z        <= 32'sd0;
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `DWCC_CHECK(a_res_from_done, $rose(res_valid) |-> $past(state == DONE), "result without close")
  `DWCC_CHECK(a_sum_all_found, (state == SUMRD) |-> (&found), "window walk with missing slot")
  `DWCC_CHECK(a_cmp_has_winner, (state == CMP) |-> best_seen, "compare without winner")
  `DWCC_CHECK_NEXT(a_slot_steps, (state == DONE) && (!res_valid || res_ready),
                   slot != $past(slot), "slot did not advance")

endmodule
`default_nettype wire

### tb/tb_detection_window_consistency_check.sv
`default_nettype none
module tb_detection_window_consistency_check;
  timeunit 1ns;
  timeprecision 1ps;
  import dwcc_pkg::*;

  localparam int WIN = 5;
  localparam longint CYCLE_LIMIT = 2000000;

  class window_scoreboard;
    logic [7:0] target_class;
    logic [30:0] distance_limit;
    logic signed [31:0] coef [12];
    logic signed [31:0] hx [WIN];
    logic signed [31:0] hy [WIN];
    logic signed [31:0] hz [WIN];
    bit found [WIN];
    int slot;
    bit best_seen;
    logic [15:0] best_score;
    logic signed [31:0] bx, by, bz;
    res_word_t pending [$];
    int mismatches;

    function new();
      target_class = 8'd0;
      distance_limit = 31'd655;
      foreach (coef[i]) coef[i] = '0;
      for (int i = 0; i < WIN; i++) begin
        hx[i] = '0; hy[i] = '0; hz[i] = '0; found[i] = 0;
      end
      slot = 0; best_seen = 0; best_score = '0; bx = '0; by = '0; bz = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_TARGET_CLASS) target_class = data[7:0];
      else distance_limit = data[30:0];
    endfunction

    function logic signed [31:0] xform(int r);
      logic signed [127:0] acc;
      acc = '0;
      acc += 128'($signed(coef[r*4+0])) * 128'($signed(bx));
      acc += 128'($signed(coef[r*4+1])) * 128'($signed(by));
      acc += 128'($signed(coef[r*4+2])) * 128'($signed(bz));
      acc = (acc + 128'sd32768) >>> 16;
      acc += 128'($signed(coef[r*4+3]));
      if (acc > 128'sd2147483647) return 32'h7fffffff;
      if (acc < -128'sd2147483648) return 32'h80000000;
      return acc[31:0];
    endfunction

    function logic [127:0] dev_sq(logic signed [31:0] h [WIN], logic signed [31:0] cur);
      logic signed [63:0] d;
      d = -64'(WIN) * 64'($signed(cur));
      for (int i = 0; i < WIN; i++) d += 64'($signed(h[i]));
      if (d < 0) d = -d;
      return 128'(d) * 128'(d);
    endfunction

    function void note_input(det_word_t w);
      int s;
      bit ok;
      logic [127:0] lhs, rhs;
      res_word_t r;
      if (w.kind == KIND_LOAD) begin
        if (w.row < 3) begin
          coef[w.row*4+0] = w.x; coef[w.row*4+1] = w.y;
          coef[w.row*4+2] = w.z; coef[w.row*4+3] = w.offset;
        end
        return;
      end
      if (w.present && w.class_id == target_class && (!best_seen || w.score > best_score)) begin
        best_seen = 1; best_score = w.score; bx = w.x; by = w.y; bz = w.z;
      end
      if (!w.last) return;
      s = slot;
      ok = best_seen;
      if (best_seen) begin
        hx[s] = xform(0); hy[s] = xform(1); hz[s] = xform(2);
        found[s] = 1;
        for (int i = 0; i < WIN; i++) if (!found[i]) ok = 0;
      end else begin
        found[s] = 0;
      end
      if (ok) begin
        lhs = dev_sq(hx, hx[s]) + dev_sq(hy, hy[s]) + dev_sq(hz, hz[s]);
        rhs = 128'(64'(WIN) * 64'(distance_limit)) * 128'(64'(WIN) * 64'(distance_limit));
        if (lhs > rhs) ok = 0;
      end
      r.valid_res = ok; r.pos_x = hx[s]; r.pos_y = hy[s]; r.pos_z = hz[s];
      pending = {pending, r};
      slot = (s + 1) % WIN;
      best_seen = 0; best_score = '0; bx = '0; by = '0; bz = '0;
    endfunction

    function void check_result(res_word_t got);
      res_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp v=%0d %h %h %h got v=%0d %h %h %h",
                   exp_w.valid_res, exp_w.pos_x, exp_w.pos_y, exp_w.pos_z,
                   got.valid_res, got.pos_x, got.pos_y, got.pos_z);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic det_valid = 0;
  logic det_ready;
  det_word_t det = '0;
  logic res_valid;
  logic res_ready = 0;
  res_word_t res;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = REG_TARGET_CLASS;
  logic [31:0] cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;
  window_scoreboard sb;

  always #4 clk = ~clk;

  detection_window_consistency_check #(.WINDOW(WIN)) i_dut (
    .clk(clk), .rst(rst),
    .det_valid(det_valid), .det_ready(det_ready), .det(det),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("detection_window_consistency_check regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res);
    if (rst) res_ready <= 0;
    else res_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_cfg(logic idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic send_word(det_word_t w);
    if ($urandom_range(99) < send_idle) begin
      det_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    det <= w;
    det_valid <= 1;
    do @(posedge clk); while (!det_ready);
    sb.note_input(w);
  endtask

  task automatic drain();
    det_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic det_word_t load_word(logic [1:0] r, logic [31:0] a, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] o);
    det_word_t w;
    w = '0; w.kind = KIND_LOAD; w.row = r; w.x = a; w.y = b; w.z = c; w.offset = o;
    w.present = 1'($urandom); w.last = 1'($urandom);
    return w;
  endfunction

  function automatic det_word_t det_word(bit pres, logic [7:0] cls, logic [15:0] sc,
                                         logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                         bit lst);
    det_word_t w;
    w = '0; w.kind = KIND_DETECT; w.present = pres; w.class_id = cls; w.score = sc;
    w.x = a; w.y = b; w.z = c; w.last = lst; w.row = 2'($urandom); w.offset = $urandom;
    return w;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 40000)) - 20000);
      1: return $urandom;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // random identity-like transform with small perturbation, or a fully random one when wild
  task automatic load_rows(bit wild);
    for (int r = 0; r < 3; r++) begin
      logic [31:0] c [3];
      for (int k = 0; k < 3; k++)
        c[k] = wild ? $urandom :
               ((k == r) ? 32'h10000 : 32'($signed($urandom_range(0, 2000)) - 1000));
      send_word(load_word(r[1:0], c[0], c[1], c[2], wild ? $urandom : rand_coord(0)));
    end
  endtask

  task automatic random_frame(logic [7:0] tgt, int mode);
    int n;
    logic [31:0] base [3];
    n = $urandom_range(1, 4);
    for (int k = 0; k < 3; k++) base[k] = rand_coord(mode);
    for (int i = 0; i < n; i++) begin
      bit pres;
      logic [7:0] cls;
      pres = ($urandom_range(9) != 0);
      cls = ($urandom_range(4) != 0) ? tgt : 8'($urandom);
      send_word(det_word(pres, cls, ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom),
                         base[0] + 32'($urandom_range(0, 600)),
                         base[1] + 32'($urandom_range(0, 600)),
                         base[2] + 32'($urandom_range(0, 600)), i == n - 1));
      if ($urandom_range(19) == 0) send_word(load_word(2'($urandom), $urandom, $urandom,
                                                      $urandom, $urandom));
    end
  endtask

  task automatic random_phase(int count, logic [7:0] tgt);
    for (int i = 0; i < count; i++) begin
      int m;
      m = $urandom_range(99);
      if (m < 3) load_rows($urandom_range(1));
      else random_frame(tgt, (m < 85) ? 0 : ((m < 95) ? 1 : 2));
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: identity transform, extremes, empty frame, tie, row 3
    send_word(load_word(2'd0, 32'h10000, 0, 0, 0));
    send_word(load_word(2'd1, 0, 32'h10000, 0, 0));
    send_word(load_word(2'd2, 0, 0, 32'h10000, 0));
    send_word(load_word(2'd3, $urandom, $urandom, $urandom, $urandom));
    send_word(det_word(0, 8'd0, 16'd0, 0, 0, 0, 1));
    for (int i = 0; i < 5; i++)
      send_word(det_word(1, 8'd0, 16'd100, 32'h1000, 32'h2000, 32'h3000, 1));
    send_word(det_word(1, 8'd0, 16'd5, 32'h7fffffff, 32'h80000000, 0, 0));
    send_word(det_word(1, 8'd0, 16'd5, 32'h1, 32'h1, 32'h1, 0));
    send_word(det_word(1, 8'd0, 16'hffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1));
    send_word(det_word(1, 8'd7, 16'hffff, 0, 0, 0, 1));
    send_word(load_word(2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_word(det_word(1, 8'd0, 16'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    send_word(load_word(2'd1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    send_word(det_word(1, 8'd0, 16'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    drain();

    write_cfg(REG_TARGET_CLASS, 32'hff);
    write_cfg(REG_DISTANCE_LIMIT, 32'h7fffffff);
    cfg_valid <= 0;
    send_idle = 35; recv_idle = 52;
    load_rows(0);
    random_phase(150, 8'hff);
    drain();

    write_cfg(REG_TARGET_CLASS, 32'h5a);
    write_cfg(REG_DISTANCE_LIMIT, 32'd0);
    cfg_valid <= 0;
    send_idle = 52; recv_idle = 35;
    random_phase(100, 8'h5a);
    drain();

    write_cfg(REG_TARGET_CLASS, 32'h00);
    write_cfg(REG_DISTANCE_LIMIT, 32'd400);
    cfg_valid <= 0;
    send_idle = 0; recv_idle = 0;
    random_phase(150, 8'h00);
    drain();

    write_cfg(REG_TARGET_CLASS, 32'h81);
    write_cfg(REG_DISTANCE_LIMIT, 32'hffffffff);
    cfg_valid <= 0;
    send_idle = 0; recv_idle = 0;
    random_phase(100, 8'h81);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("detection_window_consistency_check regression: pass");
    else
      $display("detection_window_consistency_check regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/dwcc_pkg.sv
hw/rtl/dwcc_ram.sv
hw/rtl/detection_window_consistency_check.sv
tb/tb_detection_window_consistency_check.sv
